// ===== src/sarr_pkg.sv =====
// Shared types and constants for the shift array insert/delete/search unit.
package sarr_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int FND_W  = 4;
  localparam int FILL_W = 5;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Per-cell next-value select
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_LOAD  = 2'd3
  } sel_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FND_W-1:0]         found_position;
    logic signed [WORD_W-1:0] read_value;
    logic [FILL_W-1:0]        fill_count;
  } out_word_t;

endpackage

// ===== src/sarr_cell.sv =====
// One storage cell of the array: holds an entry, shifts with neighbors, compares to a key.
module sarr_cell import sarr_pkg::*; (
  input  logic                     clk,
  input  sel_t                     sel,
  input  logic signed [WORD_W-1:0] left_val,
  input  logic signed [WORD_W-1:0] right_val,
  input  logic signed [WORD_W-1:0] load_val,
  input  logic signed [WORD_W-1:0] key,
  output logic signed [WORD_W-1:0] entry,
  output logic                     match
);

  logic signed [WORD_W-1:0] entry_r;
  logic signed [WORD_W-1:0] entry_nxt;

  // next entry: hold, take from a neighbor, or load the new word
  always_comb begin
    unique case (sel)
      SEL_HOLD:  entry_nxt = entry_r;
      SEL_LEFT:  entry_nxt = left_val;
      SEL_RIGHT: entry_nxt = right_val;
      SEL_LOAD:  entry_nxt = load_val;
      default:   entry_nxt = entry_r;
    endcase
  end

  // entry storage, no reset (contents meaningless until written)
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == key);

endmodule

// ===== src/shift_array_insert_delete_search_unit.sv =====
// Top level: packed array of signed words with insert, delete, search and read commands.
//
// Usage:
//   Input channel in_valid/in_stall/in_word carries one command word
//   (command, position, value). Output channel out_valid/out_stall/out_word
//   returns exactly one result word per command (status, found_position,
//   read_value, fill_count).
//   Each entry lives in its own cell; on insert or delete every cell at or
//   above the position loads its neighbor (on insert, the new word at the
//   position) in the same cycle; on search all cells check the key at once.
//   Latency: the result word is valid the cycle after the command is taken.
//   Throughput: one command per cycle unless stalled; the array and count
//   update in the accepting cycle, so the next command sees them right away.
//   Stall: a single output register holds the result; while it is full and
//   out_stall is high, in_stall is raised and the command waits.
//   Reset: rst_n low empties the array (fill count zero) and drops
//   out_valid; entry contents and the held result word are left as is, and
//   entries are never read until rewritten.
module shift_array_insert_delete_search_unit import sarr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        res;
  logic             accept;
  logic             ins_ok;
  logic             del_ok;
  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    cnt_w;
  logic [IDX_W-1:0] rd_idx;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;

  sel_t                     sel   [DEPTH];
  logic signed [WORD_W-1:0] entry [DEPTH];
  logic                     match [DEPTH];

  // handshake: take a word whenever the output slot is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_w  = CW'(in_word.position);
  assign cnt_w  = CW'(count_r);
  assign rd_idx = IDX_W'(pos_w);

  // lowest occupied cell that matches the key
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (CW'(i) < cnt_w)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // command decode and result word
  always_comb begin
    res            = '0;
    res.status     = ST_OK;
    count_nxt      = count_r;
    ins_ok         = 1'b0;
    del_ok         = 1'b0;
    unique case (in_word.command)
      CMD_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          res.status = ST_RANGE;
        end else begin
          ins_ok    = 1'b1;
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      CMD_DELETE: begin
        if (pos_w >= cnt_w) begin
          res.status = ST_RANGE;
        end else begin
          del_ok    = 1'b1;
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (hit_any) begin
          res.found_position = FND_W'(hit_idx);
        end else begin
          res.status = ST_MISS;
        end
      end
      CMD_READ: begin
        if (pos_w >= cnt_w) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = entry[rd_idx];
        end
      end
      default: res.status = ST_OK;
    endcase
    res.fill_count = FILL_W'(count_nxt);
  end

  // per-cell shift select
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SEL_HOLD;
      if (accept && ins_ok) begin
        if (CW'(i) == pos_w) begin
          sel[i] = SEL_LOAD;
        end else if (CW'(i) > pos_w) begin
          sel[i] = SEL_LEFT;
        end
      end else if (accept && del_ok && (CW'(i) >= pos_w)) begin
        sel[i] = SEL_RIGHT;
      end
    end
  end

  // row of cells; end cells take the new word / zero at the open edges
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] lft;
    logic signed [WORD_W-1:0] rgt;
    if (g == 0) begin : g_first
      assign lft = in_word.value;
    end else begin : g_mid_l
      assign lft = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = entry[g+1];
    end
    sarr_cell u_cell (
      .clk       (clk),
      .sel       (sel[g]),
      .left_val  (lft),
      .right_val (rgt),
      .load_val  (in_word.value),
      .key       (in_word.value),
      .entry     (entry[g]),
      .match     (match[g])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // fill count never runs past the array size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // every taken command yields a result word next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("missing result after accept");

  // successful insert grows the array by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ins_ok) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not bump fill count");

  // a full rejection reports a full array
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status == ST_FULL))
      |-> (out_word_r.fill_count == FILL_W'(DEPTH)))
    else $error("full status with partial fill");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for the shift array unit: directed and random command words checked by a predictor.
module tb;
  import sarr_pkg::*;

  localparam int DEPTH      = 16;
  localparam int RAND_WORDS = 700;
  localparam int HOLD_START = 300;
  localparam int HOLD_LEN   = 200;
  localparam int DRAIN_CYC  = 8;
  localparam int LIMIT_CYC  = 200000;
  localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] W_TAG = 32'h5A5A_A5A5;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  cmd_q[$];
  out_word_t result_q[$];
  out_word_t want_w;
  int        err_cnt = 0;

  // predicted array contents and fill count
  logic [WORD_W-1:0] arr_model [DEPTH];
  int                fill_model = 0;

  // contents as planned while generating, used to aim positions and search keys
  logic [WORD_W-1:0] plan_q[$];
  logic [WORD_W-1:0] pool [8];

  int       gap_left = 0;
  int       burst_left = 0;
  int       rx_cycle = 0;
  rx_mode_t rx_mode = RX_FREE;

  shift_array_insert_delete_search_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  // Apply one command to the predicted array and return its result word
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int        i;
    r = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_INSERT: begin
        if (fill_model >= DEPTH) begin
          r.status = ST_FULL;
        end else if (w.position > fill_model) begin
          r.status = ST_RANGE;
        end else begin
          for (i = fill_model; i > w.position; i--) arr_model[i] = arr_model[i-1];
          arr_model[w.position] = w.value;
          fill_model++;
        end
      end
      CMD_DELETE: begin
        if (w.position >= fill_model) begin
          r.status = ST_RANGE;
        end else begin
          for (i = w.position; i + 1 < fill_model; i++) arr_model[i] = arr_model[i+1];
          fill_model--;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_MISS;
        // full 32-bit compare, lowest index wins
        for (i = 0; i < fill_model; i++) begin
          if (r.status == ST_MISS && arr_model[i] == w.value) begin
            r.status = ST_OK;
            r.found_position = i[FND_W-1:0];
          end
        end
      end
      default: begin
        if (w.position >= fill_model) r.status = ST_RANGE;
        else r.read_value = arr_model[w.position];
      end
    endcase
    r.fill_count = fill_model[FILL_W-1:0];
    return r;
  endfunction

  // Queue a command word and track what it does to the planned contents
  function automatic void push_cmd(logic [1:0] c, int p, logic [WORD_W-1:0] v);
    in_word_t w;
    w.command  = c;
    w.position = p[POS_W-1:0];
    w.value    = v;
    cmd_q.push_back(w);
    if (c == CMD_INSERT && plan_q.size() < DEPTH && w.position <= plan_q.size())
      plan_q.insert(w.position, v);
    else if (c == CMD_DELETE && w.position < plan_q.size())
      plan_q.delete(w.position);
  endfunction

  // Word values: extremes, a small pool for duplicates, and plain random
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return W_MIN;
      1:       return W_MAX;
      2, 3:    return pool[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Sender: bursts of words with random gaps; payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) result_q.push_back(apply_command(in_word));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word  <= cmd_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern redrawn at random over time, with one long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= !out_stall;
      endcase
    end

    // check each accepted result word against the oldest prediction
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        err_cnt++;
      end else begin
        want_w = result_q.pop_front();
        cmp_field("status", 32'(want_w.status), 32'(out_word.status));
        cmp_field("found_position", 32'(want_w.found_position),
                  32'(out_word.found_position));
        cmp_field("read_value", want_w.read_value, out_word.read_value);
        cmp_field("fill_count", 32'(want_w.fill_count), 32'(out_word.fill_count));
      end
    end
  end

  // Run limit
  initial begin
    #(LIMIT_CYC * 4);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    int               n;
    int               roll;
    int               ins_w;
    int               del_w;
    int               p;
    bit               grow;
    logic [WORD_W-1:0] v;

    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 32'd1;
    for (int k = 3; k < 8; k++) pool[k] = $urandom;

    // directed: empty array, past-end insert, front insert, fill up, full
    push_cmd(CMD_READ, 0, '0);
    push_cmd(CMD_DELETE, 0, '0);
    push_cmd(CMD_SEARCH, 0, '0);
    push_cmd(CMD_INSERT, 1, 32'd1);
    push_cmd(CMD_INSERT, 0, W_MIN);
    push_cmd(CMD_INSERT, 0, W_MAX);
    push_cmd(CMD_INSERT, 31, '1);
    for (int k = 2; k < DEPTH; k++)
      push_cmd(CMD_INSERT, k, (k == DEPTH - 1) ? W_TAG : (k % 2) ? W_MIN : k);
    push_cmd(CMD_INSERT, 0, '1);
    push_cmd(CMD_SEARCH, 31, W_MIN);   // duplicates: lowest index
    push_cmd(CMD_SEARCH, 0, W_TAG);    // match in the last cell
    push_cmd(CMD_READ, DEPTH - 1, '0);
    push_cmd(CMD_DELETE, 0, '0);       // shifts every entry down
    push_cmd(CMD_READ, DEPTH - 1, '0);
    push_cmd(CMD_SEARCH, 0, '1);

    // random: grow and shrink phases so full and empty both come up often
    grow = 1'b1;
    repeat (RAND_WORDS) begin
      n = plan_q.size();
      if (n == DEPTH) grow = 1'b0;
      else if (n == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;
      ins_w = grow ? 50 : 15;
      del_w = grow ? 10 : 45;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        // noise: anything the fields allow
        push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
      end else if (roll < 6 + ins_w) begin
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n);
        push_cmd(CMD_INSERT, p, pick_word());
      end else if (roll < 6 + ins_w + del_w) begin
        p = ($urandom_range(0, 9) == 0 || n == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, n - 1);
        push_cmd(CMD_DELETE, p, $urandom);
      end else if (roll < 81) begin
        v = (n > 0 && $urandom_range(0, 9) < 6) ? plan_q[$urandom_range(0, n - 1)]
                                                : pick_word();
        push_cmd(CMD_SEARCH, $urandom_range(0, 31), v);
      end else begin
        p = ($urandom_range(0, 9) == 0 || n == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, n - 1);
        push_cmd(CMD_READ, p, $urandom);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to go in and every result to come back
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
